FILE: hdl/tlbpt_pkg.sv
package tlbpt_pkg;

  // Address split: page number above the offset.
  localparam int VA_BITS      = 16;
  localparam int OFFSET_BITS  = 8;
  localparam int PAGE_BITS    = 8;
  localparam int FRAME_BITS   = 8;
  localparam int PAGE_COUNT   = 256;

  // TLB geometry; ranks run from 0 (most recent) to TLB_ENTRIES-1.
  localparam int TLB_ENTRIES  = 16;
  localparam int TLB_IDX_BITS = 4;
  localparam logic [TLB_IDX_BITS-1:0] RANK_OLDEST = TLB_IDX_BITS'(TLB_ENTRIES - 1);

  // Result of the associative TLB search.
  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } tlb_lookup_t;

  // Update request: touch the page, filling with the frame on a miss.
  typedef struct packed {
    logic                  touch;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tlb_upd_t;

endpackage

FILE: hdl/tlbpt_ram.sv
module tlbpt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tlbpt_tlb.sv
module tlbpt_tlb import tlbpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tlb_upd_t    upd,
  output tlb_lookup_t lookup
);

  logic [PAGE_BITS-1:0]    tag   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]   frame [TLB_ENTRIES];
  logic [TLB_IDX_BITS-1:0] rank  [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]  valid;

  logic [TLB_ENTRIES-1:0]  hit_vec;
  logic [TLB_IDX_BITS-1:0] hit_idx;
  logic [TLB_IDX_BITS-1:0] hit_rank;
  logic                    any_free;
  logic [TLB_IDX_BITS-1:0] free_idx;
  logic [TLB_IDX_BITS-1:0] oldest_idx;
  logic [TLB_IDX_BITS-1:0] victim;

  // Associative search; tags of valid entries are unique.
  always_comb begin
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      hit_vec[k] = valid[k] && (tag[k] == upd.page);
    end
    hit_idx = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_idx = TLB_IDX_BITS'(k);
      end
    end
    hit_rank     = rank[hit_idx];
    lookup.hit   = |hit_vec;
    lookup.frame = frame[hit_idx];
  end

  // Victim choice: the first free entry, otherwise the one holding the oldest rank.
  // With every entry valid the ranks form a permutation, so the oldest is unique.
  always_comb begin
    any_free   = ~&valid;
    free_idx   = '0;
    oldest_idx = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (!valid[k]) begin
        free_idx = TLB_IDX_BITS'(k);
      end
      if (rank[k] == RANK_OLDEST) begin
        oldest_idx = TLB_IDX_BITS'(k);
      end
    end
    victim = any_free ? free_idx : oldest_idx;
  end

  // Valid bits are the only control state here.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (upd.touch && !lookup.hit) begin
      valid[victim] <= 1'b1;
    end
  end

  // Age update and fill.
  always_ff @(posedge clk) begin
    if (upd.touch) begin
      if (lookup.hit) begin
        for (int k = 0; k < TLB_ENTRIES; k++) begin
          if (valid[k] && (TLB_IDX_BITS'(k) != hit_idx) && (rank[k] < hit_rank)) begin
            rank[k] <= rank[k] + 1'b1;
          end
        end
        rank[hit_idx] <= '0;
      end else begin
        for (int k = 0; k < TLB_ENTRIES; k++) begin
          if (valid[k] && (TLB_IDX_BITS'(k) != victim) && (rank[k] < RANK_OLDEST)) begin
            rank[k] <= rank[k] + 1'b1;
          end
        end
        rank[victim]  <= '0;
        tag[victim]   <= upd.page;
        frame[victim] <= upd.frame;
      end
    end
  end

endmodule

FILE: hdl/tlb_lru_page_translator.sv
// Channel   Ports                                        Handshake
// request   virtual_address                              start, busy (taken when start && !busy)
// result    physical_address, tlb_hit, page_fault        done (one-cycle strobe)
//
// The accepting edge issues the page-table RAM read for an item,
// and the next cycle searches the TLB, writes the page table back and updates ages.
// busy is high for that lookup cycle only; done follows in the cycle after it, while
// the next item may already be accepted. Reset is synchronous; the page-table RAM
// needs no clearing pass since its valid bits are flip-flops.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tlb_lru_page_translator import tlbpt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [VA_BITS-1:0]  virtual_address,
  output logic                done,
  output logic [VA_BITS-1:0]  physical_address,
  output logic                tlb_hit,
  output logic                page_fault
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                    state;
  logic                    accept;
  logic [VA_BITS-1:0]      va;
  logic [PAGE_BITS-1:0]    page_in;
  logic [PAGE_BITS-1:0]    page;
  logic [PAGE_COUNT-1:0]   table_valid;
  logic                    pt_valid;
  logic [FRAME_BITS-1:0]   pt_frame;
  logic [FRAME_BITS-1:0]   next_free_frame;
  logic [FRAME_BITS-1:0]   miss_frame;
  logic                    fault;
  logic [FRAME_BITS-1:0]   frame;
  tlb_upd_t                upd;
  tlb_lookup_t             lookup;

  assign accept  = start && !busy;
  assign busy    = (state == ST_LOOK);
  assign page_in = virtual_address[OFFSET_BITS +: PAGE_BITS];
  assign page    = va[OFFSET_BITS +: PAGE_BITS];

  // Sequencer: enters the lookup state after each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= ST_LOOK;
    end else begin
      state <= ST_IDLE;
    end
  end

  // Capture the item and its page-table valid bit alongside the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      va       <= virtual_address;
      pt_valid <= table_valid[page_in];
    end
  end

  tlbpt_ram #(
    .DEPTH(PAGE_COUNT),
    .WIDTH(FRAME_BITS)
  ) u_page_table (
    .clk  (clk),
    .we   (busy && fault),
    .waddr(page),
    .wdata(next_free_frame),
    .re   (accept),
    .raddr(page_in),
    .rdata(pt_frame)
  );

  // Frame a TLB miss would use: the page table's, otherwise a new frame.
  // The TLB request is built from busy, the page and this frame, never from the TLB's own search.
  assign miss_frame = pt_valid ? pt_frame : next_free_frame;
  assign upd        = {busy, page, miss_frame};

  // Frame choice: TLB first, then the page table, otherwise a new frame.
  always_comb begin
    fault     = !lookup.hit && !pt_valid;
    if (lookup.hit) begin
      frame = lookup.frame;
    end else begin
      frame = miss_frame;
    end
  end

  tlbpt_tlb u_tlb (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .lookup(lookup)
  );

  // Page-table valid bits and the free-frame counter, which wraps.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid     <= '0;
      next_free_frame <= '0;
    end else if (busy && fault) begin
      table_valid[page] <= 1'b1;
      next_free_frame   <= next_free_frame + 1'b1;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      physical_address <= {frame, va[OFFSET_BITS-1:0]};
      tlb_hit          <= lookup.hit;
      page_fault       <= fault;
    end
  end

  // A result strobe is always preceded by a lookup cycle.
  a_done_after_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding lookup cycle");

  // The lookup state is never held over: busy drops after each lookup.
  a_look_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("lookup cycle held for more than one cycle");

  // An accepted item always enters the lookup cycle.
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start a lookup");

  // A TLB hit never faults.
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    done |-> !(tlb_hit && page_fault))
    else $error("result flags both a TLB hit and a page fault");

endmodule
